// File: src/mpeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-point envelope generator package
// Shared types, codes and constants of the envelope generator core.
// ----------------------------------------------------------------------------
package mpeg_pkg;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_START   = 3'd2,
    CMD_DECAY   = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    PH_OFF     = 4'd0,
    PH_INIT    = 4'd1,
    PH_RESTART = 4'd2,
    PH_LOOP    = 4'd3,
    PH_FADE    = 4'd4,
    PH_HANG    = 4'd5,
    PH_DECAY   = 4'd6,
    PH_RELEASE = 4'd7,
    PH_SUSTAIN = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    CFG_TICKS   = 2'd0,
    CFG_BUFFERS = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_FADE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ,
    ST_EVAL,
    ST_JUMP_WAIT,
    ST_SCALE_MUL,
    ST_SCALE_WAIT,
    ST_SQ_MUL,
    ST_DIFF,
    ST_RAMP_DIV,
    ST_RAMP_WAIT,
    ST_FADE,
    ST_FLAGS,
    ST_OUT
  } state_e;

  localparam int DIVD_W = 32;
  localparam int DIVS_W = 16;

  localparam logic signed [15:0] DLY_DISABLE = 16'sd0;
  localparam logic signed [15:0] DLY_HANG    = -16'sd1;
  localparam logic signed [15:0] DLY_JUMP    = -16'sd2;
  localparam logic signed [15:0] DLY_RESTART = -16'sd3;
  localparam logic signed [15:0] DLY_SCALED  = 16'sd4;
  localparam logic [15:0]        DELAY_MAX   = 16'd32767;

  localparam logic [24:0]        ONE_Q24       = 25'h100_0000;
  localparam logic signed [31:0] ONE_Q24_S     = 32'sh0100_0000;
  localparam logic signed [31:0] FLOOR_Q24     = 32'sd168;
  localparam logic signed [16:0] SUSTAIN_TICKS = 17'sd128;
  localparam logic signed [31:0] LEVEL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] LEVEL_MIN     = 32'sh8000_0000;

  typedef struct packed {
    logic               hang_request;
    logic signed [15:0] point_value;
    logic signed [15:0] point_delay;
    logic [3:0]         point_index;
    cmd_e               command;
  } item_t;

  typedef struct packed {
    logic [24:0] fade_out_step;
    logic [24:0] sustain_level;
    logic [7:0]  buffer_count;
    logic [7:0]  ticks_per_update;
  } cfg_t;

  typedef struct packed {
    logic release_req;
    logic decay_req;
    logic hang_req;
  } flags_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    phase_e      phase;
    logic [24:0] level;
  } result_t;

endpackage

// File: src/mpeg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpeg_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mpeg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// delay scaling, the ramp step and the jump index reduction.
// ----------------------------------------------------------------------------
module mpeg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpeg_pkg::div_req_t  req_i,
  output mpeg_pkg::div_rsp_t  rsp_o
);

  localparam int CntW = $clog2(mpeg_pkg::DIVD_W);
  localparam logic [CntW-1:0] CntLast = CntW'(mpeg_pkg::DIVD_W - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [mpeg_pkg::DIVD_W-1:0]   quot_q, quot_d;
  logic [mpeg_pkg::DIVS_W-1:0]   rem_q, rem_d;
  logic [mpeg_pkg::DIVS_W-1:0]   dvs_q, dvs_d;
  logic [mpeg_pkg::DIVS_W:0]     trial;
  logic                          fits;

  always_comb begin
    trial = {rem_q, quot_q[mpeg_pkg::DIVD_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[mpeg_pkg::DIVD_W-2:0], fits};
      rem_d  = fits ? mpeg_pkg::DIVS_W'(trial - {1'b0, dvs_q}) : trial[mpeg_pkg::DIVS_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: src/mpeg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope sequencer
// Holds the envelope state and steps one word through the table walk,
// the shared divider and the level update.
// ----------------------------------------------------------------------------
module mpeg_seq #(
  parameter int POINTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mpeg_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mpeg_pkg::item_t           item_i,
  input  logic                      out_free_i,
  output logic                      out_load_o,
  output mpeg_pkg::result_t         result_o,
  output logic                      ram_we_o,
  output logic [$clog2(POINTS)-1:0] ram_waddr_o,
  output logic [31:0]               ram_wdata_o,
  output logic [$clog2(POINTS)-1:0] ram_raddr_o,
  input  logic [31:0]               ram_rdata_i,
  output mpeg_pkg::div_req_t        div_req_o,
  input  mpeg_pkg::div_rsp_t        div_rsp_i
);

  localparam int PtrW  = $clog2(POINTS);
  localparam int JumpW = $clog2(POINTS + 1);
  localparam bit PtsPow2 = (POINTS & (POINTS - 1)) == 0;

  mpeg_pkg::state_e   state_q, state_d;
  mpeg_pkg::phase_e   phase_q, phase_d;
  mpeg_pkg::flags_t   flags_q, flags_d;
  logic signed [31:0] level_q, level_d;
  logic signed [31:0] ramp_q, ramp_d;
  logic signed [16:0] cnt_q, cnt_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [JumpW-1:0]   jumps_q, jumps_d;
  logic signed [15:0] val_q, val_d;
  logic signed [15:0] dlen_q, dlen_d;
  logic [31:0]        mul_q, mul_d;
  logic signed [33:0] diff_q, diff_d;
  logic               sign_q, sign_d;

  logic signed [15:0] rd_dly;
  logic [15:0]        rd_val;
  logic [7:0]         nb_eff;
  logic [15:0]        mul_a, mul_b;
  logic [31:0]        mul_p;
  logic [15:0]        val_abs, dlen_abs;
  logic [29:0]        scl_raw;
  logic [15:0]        scl;
  logic signed [33:0] diff_mag;
  logic [31:0]        quo;
  logic signed [31:0] ramp_res;
  logic signed [16:0] cnt_dec;
  logic signed [31:0] lvl_add, lvl_sub, sustain_s;
  logic [PtrW-1:0]    ptr_inc;
  logic               idx_ok, jumps_full;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      sat32 = mpeg_pkg::LEVEL_MAX;
    end else if (v < 33'sh1_8000_0000) begin
      sat32 = mpeg_pkg::LEVEL_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign rd_dly     = signed'(ram_rdata_i[31:16]);
  assign rd_val     = ram_rdata_i[15:0];
  assign nb_eff     = (cfg_i.buffer_count == 8'd0) ? 8'd1 : cfg_i.buffer_count;
  assign val_abs    = val_q[15] ? 16'(-val_q) : 16'(val_q);
  assign dlen_abs   = dlen_q[15] ? 16'(-dlen_q) : 16'(dlen_q);
  assign scl_raw    = div_rsp_i.quotient[31:2];
  assign diff_mag   = diff_q[33] ? -diff_q : diff_q;
  assign quo        = div_rsp_i.quotient;
  assign cnt_dec    = cnt_q - 17'sd1;
  assign lvl_add    = sat32(33'(level_q) + 33'(ramp_q));
  assign lvl_sub    = sat32(33'(level_q) - signed'({8'b0, cfg_i.fade_out_step}));
  assign sustain_s  = signed'({7'b0, cfg_i.sustain_level});
  assign ptr_inc    = (ptr_q == PtrW'(POINTS - 1)) ? '0 : ptr_q + 1'b1;
  assign idx_ok     = 9'(item_i.point_index) < 9'(POINTS);
  assign jumps_full = jumps_q >= JumpW'(POINTS);

  always_comb begin
    if (dlen_q > 16'sd0 && scl_raw > 30'(mpeg_pkg::DELAY_MAX)) begin
      scl = mpeg_pkg::DELAY_MAX;
    end else if (scl_raw == 30'd0) begin
      scl = 16'd1;
    end else begin
      scl = scl_raw[15:0];
    end
  end

  always_comb begin
    if (sign_q) begin
      ramp_res = (quo > 32'h8000_0000) ? mpeg_pkg::LEVEL_MIN : signed'(-quo);
    end else begin
      ramp_res = (quo > 32'h7FFF_FFFF) ? mpeg_pkg::LEVEL_MAX : signed'(quo);
    end
  end

  always_comb begin
    if (state_q == mpeg_pkg::ST_SCALE_MUL) begin
      mul_a = 16'(dlen_q);
      mul_b = {8'b0, cfg_i.ticks_per_update};
    end else begin
      mul_a = val_abs;
      mul_b = val_abs;
    end
    mul_p = mul_a * mul_b;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpeg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (item_i.command == mpeg_pkg::CMD_TICK) ? mpeg_pkg::ST_TICK
                                                          : mpeg_pkg::ST_OUT;
        end
      end
      mpeg_pkg::ST_TICK: begin
        case (phase_q)
          mpeg_pkg::PH_OFF: state_d = mpeg_pkg::ST_OUT;
          mpeg_pkg::PH_INIT: begin
            state_d = flags_q.hang_req ? mpeg_pkg::ST_FLAGS : mpeg_pkg::ST_READ;
          end
          mpeg_pkg::PH_RESTART, mpeg_pkg::PH_LOOP: state_d = mpeg_pkg::ST_READ;
          mpeg_pkg::PH_FADE: state_d = mpeg_pkg::ST_FADE;
          default: state_d = mpeg_pkg::ST_FLAGS;
        endcase
      end
      mpeg_pkg::ST_READ: state_d = mpeg_pkg::ST_EVAL;
      mpeg_pkg::ST_EVAL: begin
        if (rd_dly == mpeg_pkg::DLY_DISABLE || rd_dly == mpeg_pkg::DLY_HANG ||
            rd_dly == mpeg_pkg::DLY_RESTART) begin
          state_d = mpeg_pkg::ST_FLAGS;
        end else if (rd_dly == mpeg_pkg::DLY_JUMP) begin
          if (jumps_full) begin
            state_d = mpeg_pkg::ST_FLAGS;
          end else begin
            state_d = PtsPow2 ? mpeg_pkg::ST_READ : mpeg_pkg::ST_JUMP_WAIT;
          end
        end else if (rd_dly >= mpeg_pkg::DLY_SCALED) begin
          state_d = mpeg_pkg::ST_SCALE_MUL;
        end else begin
          state_d = mpeg_pkg::ST_SQ_MUL;
        end
      end
      mpeg_pkg::ST_JUMP_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = mpeg_pkg::ST_READ;
        end
      end
      mpeg_pkg::ST_SCALE_MUL: state_d = mpeg_pkg::ST_SCALE_WAIT;
      mpeg_pkg::ST_SCALE_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = mpeg_pkg::ST_SQ_MUL;
        end
      end
      mpeg_pkg::ST_SQ_MUL: state_d = mpeg_pkg::ST_DIFF;
      mpeg_pkg::ST_DIFF: state_d = mpeg_pkg::ST_RAMP_DIV;
      mpeg_pkg::ST_RAMP_DIV: state_d = mpeg_pkg::ST_RAMP_WAIT;
      mpeg_pkg::ST_RAMP_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = mpeg_pkg::ST_FADE;
        end
      end
      mpeg_pkg::ST_FADE: state_d = mpeg_pkg::ST_FLAGS;
      mpeg_pkg::ST_FLAGS: state_d = mpeg_pkg::ST_OUT;
      mpeg_pkg::ST_OUT: begin
        if (out_free_i) begin
          state_d = mpeg_pkg::ST_IDLE;
        end
      end
      default: state_d = mpeg_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_d   = phase_q;
    flags_d   = flags_q;
    level_d   = level_q;
    ramp_d    = ramp_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    jumps_d   = jumps_q;
    val_d     = val_q;
    dlen_d    = dlen_q;
    mul_d     = mul_q;
    diff_d    = diff_q;
    sign_d    = sign_q;
    ram_we_o  = 1'b0;
    div_req_o = '0;
    out_load_o = 1'b0;
    case (state_q)
      mpeg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (item_i.command)
            mpeg_pkg::CMD_LOAD: ram_we_o = idx_ok;
            mpeg_pkg::CMD_START: begin
              level_d = '0;
              ramp_d  = '0;
              cnt_d   = '0;
              ptr_d   = '0;
              phase_d = mpeg_pkg::PH_INIT;
              flags_d = '{release_req: 1'b0, decay_req: 1'b0,
                          hang_req: item_i.hang_request};
            end
            mpeg_pkg::CMD_DECAY: flags_d.decay_req = 1'b1;
            mpeg_pkg::CMD_RELEASE: flags_d.release_req = 1'b1;
            default: ;
          endcase
        end
      end
      mpeg_pkg::ST_TICK: begin
        case (phase_q)
          mpeg_pkg::PH_INIT: begin
            if (flags_q.hang_req) begin
              phase_d = mpeg_pkg::PH_HANG;
            end else begin
              ptr_d   = '0;
              phase_d = mpeg_pkg::PH_LOOP;
              jumps_d = '0;
            end
          end
          mpeg_pkg::PH_RESTART: begin
            ptr_d   = '0;
            phase_d = mpeg_pkg::PH_LOOP;
            jumps_d = '0;
          end
          mpeg_pkg::PH_LOOP: jumps_d = '0;
          mpeg_pkg::PH_DECAY, mpeg_pkg::PH_RELEASE: begin
            level_d = lvl_sub;
            if (cfg_i.sustain_level != '0 && phase_q == mpeg_pkg::PH_DECAY) begin
              if (lvl_sub < sustain_s) begin
                level_d = sustain_s;
                cnt_d   = mpeg_pkg::SUSTAIN_TICKS;
                phase_d = mpeg_pkg::PH_SUSTAIN;
              end
            end else if (lvl_sub < mpeg_pkg::FLOOR_Q24) begin
              level_d = '0;
              phase_d = mpeg_pkg::PH_OFF;
            end
          end
          mpeg_pkg::PH_SUSTAIN: begin
            cnt_d = cnt_dec;
            if (cnt_dec == 17'sd0) begin
              phase_d = mpeg_pkg::PH_RELEASE;
            end
          end
          default: ;
        endcase
      end
      mpeg_pkg::ST_EVAL: begin
        val_d  = signed'(rd_val);
        dlen_d = rd_dly;
        if (rd_dly == mpeg_pkg::DLY_DISABLE) begin
          phase_d = mpeg_pkg::PH_OFF;
        end else if (rd_dly == mpeg_pkg::DLY_HANG) begin
          phase_d = mpeg_pkg::PH_HANG;
        end else if (rd_dly == mpeg_pkg::DLY_RESTART) begin
          phase_d = mpeg_pkg::PH_INIT;
        end else if (rd_dly == mpeg_pkg::DLY_JUMP) begin
          if (jumps_full) begin
            phase_d = mpeg_pkg::PH_OFF;
          end else begin
            jumps_d = jumps_q + 1'b1;
            if (PtsPow2) begin
              ptr_d = PtrW'(rd_val);
            end else begin
              div_req_o.start    = 1'b1;
              div_req_o.dividend = {16'b0, rd_val};
              div_req_o.divisor  = mpeg_pkg::DIVS_W'(POINTS);
            end
          end
        end
      end
      mpeg_pkg::ST_JUMP_WAIT: begin
        if (div_rsp_i.done) begin
          ptr_d = PtrW'(div_rsp_i.remainder);
        end
      end
      mpeg_pkg::ST_SCALE_MUL: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = mul_p;
        div_req_o.divisor  = {8'b0, nb_eff};
      end
      mpeg_pkg::ST_SCALE_WAIT: begin
        if (div_rsp_i.done) begin
          dlen_d = signed'(scl);
        end
      end
      mpeg_pkg::ST_SQ_MUL: mul_d = mul_p;
      mpeg_pkg::ST_DIFF: begin
        diff_d = signed'({8'b0, mul_q[31:6]}) - 34'(level_q);
      end
      mpeg_pkg::ST_RAMP_DIV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = diff_mag[31:0];
        div_req_o.divisor  = dlen_abs;
        sign_d             = diff_q[33] ^ dlen_q[15];
      end
      mpeg_pkg::ST_RAMP_WAIT: begin
        if (div_rsp_i.done) begin
          ramp_d  = ramp_res;
          cnt_d   = 17'(dlen_q);
          phase_d = mpeg_pkg::PH_FADE;
          ptr_d   = ptr_inc;
        end
      end
      mpeg_pkg::ST_FADE: begin
        cnt_d   = cnt_dec;
        level_d = lvl_add;
        if (cnt_dec <= 17'sd0) begin
          phase_d = mpeg_pkg::PH_LOOP;
        end
      end
      mpeg_pkg::ST_FLAGS: begin
        if (flags_q.decay_req) begin
          phase_d           = mpeg_pkg::PH_DECAY;
          flags_d.decay_req = 1'b0;
        end
        if (flags_q.release_req) begin
          phase_d             = mpeg_pkg::PH_RELEASE;
          flags_d.release_req = 1'b0;
        end
      end
      mpeg_pkg::ST_OUT: out_load_o = out_free_i;
      default: ;
    endcase
  end

  always_comb begin
    result_o.phase = phase_q;
    if (phase_q == mpeg_pkg::PH_OFF || level_q[31]) begin
      result_o.level = '0;
    end else if (level_q > mpeg_pkg::ONE_Q24_S) begin
      result_o.level = mpeg_pkg::ONE_Q24;
    end else begin
      result_o.level = level_q[24:0];
    end
  end

  assign in_ready_o  = (state_q == mpeg_pkg::ST_IDLE);
  assign ram_waddr_o = PtrW'(item_i.point_index);
  assign ram_wdata_o = {item_i.point_delay, item_i.point_value};
  assign ram_raddr_o = ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpeg_pkg::ST_IDLE;
      phase_q <= mpeg_pkg::PH_OFF;
      flags_q <= '0;
      level_q <= '0;
      ramp_q  <= '0;
      cnt_q   <= '0;
      ptr_q   <= '0;
      jumps_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      flags_q <= flags_d;
      level_q <= level_d;
      ramp_q  <= ramp_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      jumps_q <= jumps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    dlen_q <= dlen_d;
    mul_q  <= mul_d;
    diff_q <= diff_d;
    sign_q <= sign_d;
  end

endmodule

// File: src/multi_point_envelope_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-point envelope generator core
// Table driven volume envelope with ramps, jumps, decay, sustain and release.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals           Contents (lowest bit first)
// s_axis    in   tdata[39:0]       point_index[3:0], point_delay[19:4],
//                                  point_value[35:20], hang_request[36]
//                s_axis tuser[2:0] command
// m_axis    out  tdata[31:0]       level[24:0], phase[28:25]
// cfg       in   we, idx, data     ticks_per_update, buffer_count,
//                                  sustain_level, fade_out_step
//
// A non-tick word goes straight to the output state. A tick goes there
// directly while off, via the flag step in hang, decay, release or sustain,
// and via the fade and flag steps on a ramp step. A walk reads and evaluates
// an entry and goes to the flag step at a control point; a new ramp point
// takes a divider pass, after one more with delay scaling. Each jump reads
// again, after a divider pass when POINTS is not a power of two. The table
// has no clearing pass after reset. An untaken result holds the sequencer.
module multi_point_envelope_generator_core #(
  parameter int POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // point_index, point_delay, point_value, hang_request, zero padding
  input  logic [39:0] s_axis_tdata_i,
  // command
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // level, phase, zero padding
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_data_i
);

  localparam int PtrW = $clog2(POINTS);

  mpeg_pkg::cfg_t     cfg_q, cfg_d;
  mpeg_pkg::item_t    item;
  mpeg_pkg::result_t  result;
  mpeg_pkg::result_t  out_q;
  mpeg_pkg::div_req_t div_req;
  mpeg_pkg::div_rsp_t div_rsp;
  logic               out_valid_q, out_valid_d;
  logic               out_free, out_load;
  logic               ram_we;
  logic [PtrW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  assign item.command      = mpeg_pkg::cmd_e'(s_axis_tuser_i);
  assign item.point_index  = s_axis_tdata_i[3:0];
  assign item.point_delay  = signed'(s_axis_tdata_i[19:4]);
  assign item.point_value  = signed'(s_axis_tdata_i[35:20]);
  assign item.hang_request = s_axis_tdata_i[36];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mpeg_pkg::cfg_idx_e'(cfg_idx_i))
        mpeg_pkg::CFG_TICKS:   cfg_d.ticks_per_update = cfg_data_i[7:0];
        mpeg_pkg::CFG_BUFFERS: cfg_d.buffer_count     = cfg_data_i[7:0];
        mpeg_pkg::CFG_SUSTAIN: cfg_d.sustain_level    = cfg_data_i;
        mpeg_pkg::CFG_FADE:    cfg_d.fade_out_step    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fade_out_step: '0, sustain_level: '0, buffer_count: 8'd1,
                 ticks_per_update: 8'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mpeg_ram #(
    .Width (32),
    .Depth (POINTS)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mpeg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mpeg_seq #(
    .POINTS (POINTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .item_i      (item),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .result_o    (result),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b0, out_q};

endmodule

// File: tb/multi_point_envelope_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-point envelope generator core testbench
// Drives command, point-load and tick words into the core with random gaps and
// back-pressure. A scoreboard class keeps its own model of the envelope state
// and checks every level and phase word that comes out, in order. A short
// directed run comes first. Random envelopes then run under several register
// settings that include the extremes.
// ----------------------------------------------------------------------------
localparam int NUM_POINTS = 16;

class envelope_scoreboard;
  localparam int DELAY_SCALE_DIV = 4;

  logic [31:0]           points [NUM_POINTS];
  bit [NUM_POINTS-1:0]   written;
  int                    level;
  int                    ramp;
  int                    countdown;
  logic [3:0]            ptr;
  mpeg_pkg::phase_e      ph;
  mpeg_pkg::flags_t      fl;
  logic [7:0]            tpu;
  logic [7:0]            nbuf;
  logic [24:0]           sus;
  logic [24:0]           fade;

  mpeg_pkg::result_t     expected_q[$];
  int                    errors;
  int                    compared;
  logic [15:0]           seen_phases;

  function new();
    written = '0;
    level = 0;
    ramp = 0;
    countdown = 0;
    ptr = '0;
    ph = mpeg_pkg::PH_OFF;
    fl = '0;
    tpu = 8'd1;
    nbuf = 8'd1;
    sus = '0;
    fade = '0;
    errors = 0;
    compared = 0;
    seen_phases = '0;
  endfunction

  function void set_reg(mpeg_pkg::cfg_idx_e idx, logic [24:0] val);
    case (idx)
      mpeg_pkg::CFG_TICKS:   tpu = val[7:0];
      mpeg_pkg::CFG_BUFFERS: nbuf = val[7:0];
      mpeg_pkg::CFG_SUSTAIN: sus = val;
      mpeg_pkg::CFG_FADE:    fade = val;
      default: ;
    endcase
  endfunction

  function int clip32(longint v);
    if (v > longint'(mpeg_pkg::LEVEL_MAX)) return mpeg_pkg::LEVEL_MAX;
    if (v < longint'(mpeg_pkg::LEVEL_MIN)) return mpeg_pkg::LEVEL_MIN;
    return int'(v);
  endfunction

  // The jump destination is the value taken as an unsigned number, modulo the table size.
  function logic [3:0] jump_dest(logic signed [15:0] val);
    return 4'(int'({16'h0000, val}) % NUM_POINTS);
  endfunction

  function void step_ramp();
    countdown--;
    level = clip32(longint'(level) + ramp);
    if (countdown <= 0) ph = mpeg_pkg::PH_LOOP;
  endfunction

  function void walk_points();
    int unsigned        jumps;
    logic signed [15:0] dly;
    logic signed [15:0] val;
    int                 span;
    int unsigned        scaled;
    int unsigned        nb;
    longint             target;
    jumps = 0;
    while (1'b1) begin
      {dly, val} = points[ptr];
      if (dly == mpeg_pkg::DLY_DISABLE) begin
        ph = mpeg_pkg::PH_OFF;
        return;
      end
      if (dly == mpeg_pkg::DLY_HANG) begin
        ph = mpeg_pkg::PH_HANG;
        return;
      end
      if (dly == mpeg_pkg::DLY_RESTART) begin
        ph = mpeg_pkg::PH_INIT;
        return;
      end
      if (dly == mpeg_pkg::DLY_JUMP) begin
        if (jumps >= NUM_POINTS) begin
          ph = mpeg_pkg::PH_OFF;
          return;
        end
        jumps++;
        ptr = jump_dest(val);
      end else begin
        span = dly;
        if (dly >= mpeg_pkg::DLY_SCALED) begin
          nb = (nbuf == 0) ? 1 : nbuf;
          scaled = span * tpu;
          scaled = scaled / nb / DELAY_SCALE_DIV;
          span = (scaled > mpeg_pkg::DELAY_MAX) ? int'(mpeg_pkg::DELAY_MAX) : int'(scaled);
        end
        if (span == 0) span = 1;
        target = (longint'(val) * val) >>> 6;
        ramp = clip32((target - level) / span);
        countdown = span;
        ph = mpeg_pkg::PH_FADE;
        ptr = ptr + 4'd1;
        return;
      end
    end
  endfunction

  function void advance_tick();
    mpeg_pkg::phase_e p;
    mpeg_pkg::flags_t f;
    p = ph;
    f = fl;
    if (p == mpeg_pkg::PH_OFF) return;
    if (p == mpeg_pkg::PH_INIT && f.hang_req) begin
      ph = mpeg_pkg::PH_HANG;
    end else if (p == mpeg_pkg::PH_INIT || p == mpeg_pkg::PH_RESTART ||
                 p == mpeg_pkg::PH_LOOP) begin
      if (p != mpeg_pkg::PH_LOOP) begin
        ptr = '0;
        ph = mpeg_pkg::PH_LOOP;
      end
      walk_points();
      if (ph == mpeg_pkg::PH_FADE) step_ramp();
    end else if (p == mpeg_pkg::PH_FADE) begin
      step_ramp();
    end else if (p == mpeg_pkg::PH_DECAY || p == mpeg_pkg::PH_RELEASE) begin
      level = clip32(longint'(level) - longint'(fade));
      if (sus != 0 && p == mpeg_pkg::PH_DECAY) begin
        if (longint'(level) < longint'(sus)) begin
          level = int'(sus);
          countdown = mpeg_pkg::SUSTAIN_TICKS;
          ph = mpeg_pkg::PH_SUSTAIN;
        end
      end else if (level < mpeg_pkg::FLOOR_Q24) begin
        level = 0;
        ph = mpeg_pkg::PH_OFF;
      end
    end else if (p == mpeg_pkg::PH_SUSTAIN) begin
      countdown--;
      if (countdown == 0) ph = mpeg_pkg::PH_RELEASE;
    end
    if (f.decay_req) begin
      ph = mpeg_pkg::PH_DECAY;
      fl.decay_req = 1'b0;
    end
    if (f.release_req) begin
      ph = mpeg_pkg::PH_RELEASE;
      fl.release_req = 1'b0;
    end
  endfunction

  // Returns a table entry that the next tick would read before it was ever written, or -1.
  function int missing_point();
    logic [3:0]         p;
    logic signed [15:0] dly;
    logic signed [15:0] val;
    if (!(ph == mpeg_pkg::PH_LOOP || ph == mpeg_pkg::PH_RESTART ||
          (ph == mpeg_pkg::PH_INIT && !fl.hang_req))) return -1;
    p = (ph == mpeg_pkg::PH_LOOP) ? ptr : 4'd0;
    for (int n = 0; n <= NUM_POINTS; n++) begin
      if (!written[p]) return int'(p);
      {dly, val} = points[p];
      if (dly != mpeg_pkg::DLY_JUMP) return -1;
      p = jump_dest(val);
    end
    return -1;
  endfunction

  function void note_word(mpeg_pkg::item_t w);
    mpeg_pkg::result_t r;
    case (w.command)
      mpeg_pkg::CMD_TICK: advance_tick();
      mpeg_pkg::CMD_LOAD: begin
        points[w.point_index] = {w.point_delay, w.point_value};
        written[w.point_index] = 1'b1;
      end
      mpeg_pkg::CMD_START: begin
        level = 0;
        ramp = 0;
        countdown = 0;
        ptr = '0;
        ph = mpeg_pkg::PH_INIT;
        fl = '0;
        fl.hang_req = w.hang_request;
      end
      mpeg_pkg::CMD_DECAY:   fl.decay_req = 1'b1;
      mpeg_pkg::CMD_RELEASE: fl.release_req = 1'b1;
      default: ;
    endcase
    r.phase = ph;
    if (ph == mpeg_pkg::PH_OFF || level < 0) r.level = '0;
    else if (level > mpeg_pkg::ONE_Q24_S) r.level = mpeg_pkg::ONE_Q24;
    else r.level = level[24:0];
    expected_q.push_back(r);
  endfunction

  function void report(string what, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  function void check_word(logic [31:0] data);
    mpeg_pkg::result_t got;
    mpeg_pkg::result_t want;
    got = data[28:0];
    seen_phases[got.phase] = 1'b1;
    compared++;
    if (expected_q.size() == 0) begin
      report("unexpected word, level", -1, got.level);
      return;
    end
    want = expected_q.pop_front();
    if (got.level !== want.level) report("level", want.level, got.level);
    if (got.phase !== want.phase) report("phase", want.phase, got.phase);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void close_out();
    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_q.size());
      errors += expected_q.size();
    end
  endfunction
endclass

module multi_point_envelope_generator_core_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int TOTAL_WORDS  = 2000;
  localparam int NUM_SETTINGS = 8;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 200;
  localparam int CMD_CODE_MAX = 7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [39:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [24:0] cfg_data_i = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [31:0] m_axis_tdata_o;

  envelope_scoreboard sb;
  bit tx_gaps_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_left = 0;
  int words_sent = 0;
  int cycle_count = 0;

  multi_point_envelope_generator_core #(
    .POINTS(NUM_POINTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int idle_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(1, 12));
    if (r < 62) return 16'($urandom_range(13, 400));
    if (r < 64) return 16'($urandom_range(401, 32767));
    if (r < 72) return mpeg_pkg::DLY_HANG;
    if (r < 80) return mpeg_pkg::DLY_JUMP;
    if (r < 86) return mpeg_pkg::DLY_RESTART;
    if (r < 89) return mpeg_pkg::DLY_DISABLE;
    return 16'(-int'($urandom_range(4, 32768)));
  endfunction

  always @(posedge clk_i) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_stall_on && m_axis_tready_i) begin
      m_axis_tready_i <= 1'b0;
      rx_left <= idle_len(1'b1);
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_left <= $urandom_range(0, 23);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
  end

  task automatic send_word(input mpeg_pkg::item_t w);
    int gap;
    gap = idle_len(tx_gaps_on);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'b000, w.hang_request, w.point_value, w.point_delay, w.point_index};
    s_axis_tuser_i <= w.command;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_load(input logic [3:0] idx, input logic signed [15:0] dly,
                           input logic signed [15:0] val);
    mpeg_pkg::item_t w;
    w.command = mpeg_pkg::CMD_LOAD;
    w.point_index = idx;
    w.point_delay = dly;
    w.point_value = val;
    w.hang_request = 1'($urandom);
    send_word(w);
  endtask

  // A tick may walk the table, so any entry it would read unwritten is loaded first.
  task automatic send_cmd(input mpeg_pkg::cmd_e c, input bit hang);
    mpeg_pkg::item_t w;
    int              m;
    if (c == mpeg_pkg::CMD_TICK) begin
      m = sb.missing_point();
      while (m >= 0) begin
        send_load(4'(m), pick_delay(), 16'($urandom));
        m = sb.missing_point();
      end
    end
    w.command = c;
    w.point_index = 4'($urandom);
    w.point_delay = 16'($urandom);
    w.point_value = 16'($urandom);
    w.hang_request = hang;
    send_word(w);
  endtask

  task automatic send_unknown();
    mpeg_pkg::item_t w;
    w.command = mpeg_pkg::cmd_e'(3'($urandom_range(int'(mpeg_pkg::CMD_RELEASE) + 1,
                                                   CMD_CODE_MAX)));
    w.point_index = 4'($urandom);
    w.point_delay = 16'($urandom);
    w.point_value = 16'($urandom);
    w.hang_request = 1'($urandom);
    send_word(w);
  endtask

  task automatic idle_bus();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results(input int limit);
    while (sb.pending() != 0 && limit > 0) begin
      @(posedge clk_i);
      limit--;
    end
  endtask

  task automatic write_reg(input mpeg_pkg::cfg_idx_e idx, input logic [24:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] tpu, input logic [7:0] nb,
                               input logic [24:0] sus, input logic [24:0] fade);
    idle_bus();
    wait_results(DRAIN_LIMIT);
    repeat (8) @(posedge clk_i);
    write_reg(mpeg_pkg::CFG_TICKS, tpu);
    write_reg(mpeg_pkg::CFG_BUFFERS, nb);
    write_reg(mpeg_pkg::CFG_SUSTAIN, sus);
    write_reg(mpeg_pkg::CFG_FADE, fade);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a short well-formed envelope: a few ramps and then a control point.
  task automatic program_envelope();
    int k;
    int r;
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++)
      send_load(4'(i), 16'($urandom_range(1, 20)), 16'($urandom));
    r = $urandom_range(0, 3);
    if (r == 0) send_load(4'(k), mpeg_pkg::DLY_HANG, 16'($urandom));
    else if (r == 1) send_load(4'(k), mpeg_pkg::DLY_RESTART, 16'($urandom));
    else if (r == 2) send_load(4'(k), mpeg_pkg::DLY_DISABLE, 16'($urandom));
    else send_load(4'(k), mpeg_pkg::DLY_JUMP,
                   {12'($urandom), 4'($urandom_range(0, k - 1))});
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_cmd(mpeg_pkg::CMD_TICK, 1'($urandom));
    end else if (r < 72) begin
      send_load(4'($urandom_range(0, NUM_POINTS - 1)), pick_delay(), 16'($urandom));
    end else if (r < 79) begin
      if ($urandom_range(0, 1) == 0) program_envelope();
      send_cmd(mpeg_pkg::CMD_START, $urandom_range(0, 3) == 0);
    end else if (r < 86) begin
      send_cmd(mpeg_pkg::CMD_DECAY, 1'($urandom));
    end else if (r < 93) begin
      send_cmd(mpeg_pkg::CMD_RELEASE, 1'($urandom));
    end else if (r < 96) begin
      send_unknown();
    end else begin
      repeat ($urandom_range(5, 40)) send_cmd(mpeg_pkg::CMD_TICK, 1'($urandom));
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped by the timeout after %0d cycles.", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int target;
    int directed_words;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_unknown();
    send_unknown();
    send_load(4'd15, -16'sd32768, 16'sd32767);
    send_load(4'd0, mpeg_pkg::DLY_JUMP, 16'sd0);
    send_cmd(mpeg_pkg::CMD_START, 1'b0);
    send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_load(4'd0, mpeg_pkg::DLY_SCALED, 16'sd32767);
    send_load(4'd1, -16'sd4, -16'sd32768);
    send_load(4'd2, mpeg_pkg::DLY_JUMP, 16'sd32756);
    send_load(4'd4, mpeg_pkg::DLY_RESTART, 16'sd0);
    send_cmd(mpeg_pkg::CMD_START, 1'b0);
    repeat (4) send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_cmd(mpeg_pkg::CMD_DECAY, 1'b0);
    repeat (2) send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_cmd(mpeg_pkg::CMD_RELEASE, 1'b1);
    send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_cmd(mpeg_pkg::CMD_START, 1'b1);
    send_cmd(mpeg_pkg::CMD_TICK, 1'b0);
    send_load(4'd3, 16'sd32767, -16'sd1);
    send_cmd(mpeg_pkg::CMD_RELEASE, 1'b0);
    send_cmd(mpeg_pkg::CMD_TICK, 1'b1);
    directed_words = words_sent;

    for (int n = 0; n < NUM_SETTINGS; n++) begin
      case (n)
        0: load_settings(8'd255, 8'd1, 25'd0, mpeg_pkg::ONE_Q24);
        1: load_settings(8'd1, 8'd255, mpeg_pkg::ONE_Q24, 25'd1);
        2: load_settings(8'd4, 8'd2, mpeg_pkg::ONE_Q24 >> 1, 25'd65536);
        default: load_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                               ($urandom_range(0, 1) == 0) ? 25'd0 :
                                 25'($urandom_range(0, mpeg_pkg::ONE_Q24)),
                               25'($urandom_range(0, mpeg_pkg::ONE_Q24) >>
                                   $urandom_range(0, 16)));
      endcase
      tx_gaps_on = (n != 0 && n != 4);
      rx_stall_on = (n != 0 && n != 3);
      target = directed_words + (TOTAL_WORDS - directed_words) * (n + 1) / NUM_SETTINGS;
      while (words_sent < target) random_step();
    end

    idle_bus();
    wait_results(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.close_out();

    $display("Covered %0d input words (%0d directed) under %0d register settings; %0d compared.",
             words_sent, directed_words, NUM_SETTINGS + 1, sb.compared);
    $display("Phase codes observed at the output, one bit per code: %b", sb.seen_phases[8:0]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/mpeg_pkg.sv
src/mpeg_ram.sv
src/mpeg_div.sv
src/mpeg_seq.sv
src/multi_point_envelope_generator_core.sv
tb/multi_point_envelope_generator_core_tb.sv
